// ----- design/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared forms for the concurrent checks at the end of the RTL modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define KTS_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("keyframe sampler check failed");

// The consequent must hold in the cycle after the antecedent.
`define KTS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("keyframe sampler check failed");

`endif

// ----- design/kts_pkg.sv -----
// ----------------------------------------------------------------------------
// Keyframe track sampler package
// Sizes, codes, state type and word formats shared by the sampler modules.
// ----------------------------------------------------------------------------
`default_nettype none

package kts_pkg;

   localparam int MAX_KEYFRAMES = 64;
   localparam int FRAC_BITS     = 16;
   localparam int WORD_W        = 32;
   localparam int FRAME_W       = 16;
   localparam int COUNT_W       = 7;
   localparam int SLOT_W        = $clog2(MAX_KEYFRAMES);
   localparam int VAL_DEPTH     = 3 * MAX_KEYFRAMES;
   localparam int VAL_AW        = $clog2(VAL_DEPTH);
   localparam int DH_W          = FRAME_W + 1;
   localparam int PROD_W        = WORD_W + DH_W;
   localparam int SUM_W         = PROD_W + 1;

   localparam logic [COUNT_W-1:0] MAX_COUNT = COUNT_W'(MAX_KEYFRAMES);
   localparam logic [WORD_W-1:0]  WORD_MAX  = {1'b0, {(WORD_W-1){1'b1}}};
   localparam logic [WORD_W-1:0]  WORD_MIN  = {1'b1, {(WORD_W-1){1'b0}}};

   localparam logic OP_LOAD   = 1'b0;
   localparam logic OP_SAMPLE = 1'b1;

   localparam logic [1:0] AXIS_X = 2'd0;
   localparam logic [1:0] AXIS_Y = 2'd1;
   localparam logic [1:0] AXIS_Z = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_FETCH,
      ST_DRAIN
   } state_type;

   typedef struct packed {
      logic                     opcode;
      logic [5:0]               slot;
      logic [1:0]               axis;
      logic [FRAME_W-1:0]       key_frame;
      logic signed [WORD_W-1:0] load_position;
      logic signed [WORD_W-1:0] load_position_delta;
      logic signed [WORD_W-1:0] load_orientation;
      logic signed [WORD_W-1:0] load_orientation_delta;
      logic [WORD_W-1:0]        query_time;
   } req_word_type;

   typedef struct packed {
      logic signed [WORD_W-1:0] pos_x;
      logic signed [WORD_W-1:0] pos_y;
      logic signed [WORD_W-1:0] pos_z;
      logic signed [WORD_W-1:0] ori_x;
      logic signed [WORD_W-1:0] ori_y;
      logic signed [WORD_W-1:0] ori_z;
      logic                     empty_track;
   } rsp_word_type;

   typedef struct packed {
      logic signed [WORD_W-1:0] position;
      logic signed [WORD_W-1:0] position_delta;
      logic signed [WORD_W-1:0] orientation;
      logic signed [WORD_W-1:0] orientation_delta;
   } val_entry_type;

endpackage

`default_nettype wire

// ----- design/kts_extrap.sv -----
// ----------------------------------------------------------------------------
// Keyframe extrapolation unit
// Registers value and delta times whole and fractional elapsed time, then
// adds, floor-scaling only the fractional product, and saturates.
// ----------------------------------------------------------------------------
`default_nettype none

module kts_extrap
   import kts_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic signed [WORD_W-1:0] value,
   input  wire logic signed [WORD_W-1:0] delta,
   input  wire logic signed [DH_W-1:0]   dh,
   input  wire logic [FRAC_BITS-1:0]     dl,
   output logic signed [WORD_W-1:0]      result
);

   logic signed [PROD_W-1:0] prod_hi_ff, prod_hi_in;
   logic signed [PROD_W-1:0] prod_lo_ff, prod_lo_in;
   logic signed [WORD_W-1:0] value_ff;
   logic signed [SUM_W-1:0]  sum;
   logic                     overflow;

   assign prod_hi_in = PROD_W'(delta) * PROD_W'(dh);
   assign prod_lo_in = PROD_W'(delta) * PROD_W'($signed({1'b0, dl}));

   always_ff @(posedge clock) begin
      prod_hi_ff <= prod_hi_in;
      prod_lo_ff <= prod_lo_in;
      value_ff   <= value;
   end

   // The whole-frame product is already in result units; only the
   // fractional product needs the floor shift.
   assign sum = SUM_W'(value_ff) + SUM_W'(prod_hi_ff) + SUM_W'(prod_lo_ff >>> FRAC_BITS);
   assign overflow = (sum[SUM_W-1:WORD_W-1] != '0) && (sum[SUM_W-1:WORD_W-1] != '1);

   always_comb begin
      if (overflow) begin
         result = sum[SUM_W-1] ? $signed(WORD_MIN) : $signed(WORD_MAX);
      end else begin
         result = sum[WORD_W-1:0];
      end
   end

endmodule

`default_nettype wire

// ----- design/keyframe_track_sampler.sv -----
// ----------------------------------------------------------------------------
// Keyframe track sampler
// Stores one animation track and samples it by linear extrapolation from
// the last keyframe at or before the requested frame (else the last slot).
// ----------------------------------------------------------------------------
// Usage: a word on req_data is taken when start is high and busy is low.
// A load word writes one axis of one keyframe slot in the cycle it is taken
// and a zero result word is strobed on rsp_valid in the following cycle.
// A sample word with an empty track likewise answers in the next cycle,
// with empty_track set. Any other sample performs a halving search over the
// frame memory, one probe per cycle, s probes for n keyframes with s at most
// ceil(log2(n + 1)) (seven for a full track), then three reads of the value
// memory, one per axis, through a two-stage multiply and add. The result
// word is flagged by rsp_valid for exactly one cycle, and busy falls in that
// same cycle. The search loop over the single read port of the frame memory
// sets the sample time. The csr port sets the keyframe count; the user must
// write it only while idle, as the block does not enforce this. Reset clears
// the count and the control state; keyframe contents are not cleared. The
// receiver cannot stall, so each result must be taken as shown.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module keyframe_track_sampler
   import kts_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   output logic                     busy,
   input  wire req_word_type        req_data,
   output logic                     rsp_valid,
   output rsp_word_type             rsp_data,
   input  wire logic                csr_we,
   input  wire logic [COUNT_W-1:0]  csr_wdata
);

   logic [FRAME_W-1:0] frame_mem [MAX_KEYFRAMES];
   val_entry_type      val_mem   [VAL_DEPTH];

   state_type            state_ff, state_in;
   logic [COUNT_W-1:0]   count_ff;
   logic [COUNT_W-1:0]   n_ff, n_in;
   logic [COUNT_W-1:0]   lo_ff, lo_in;
   logic [COUNT_W-1:0]   hi_ff, hi_in;
   logic [SLOT_W-1:0]    mid_ff, mid_in;
   logic [SLOT_W-1:0]    sel_ff, sel_in;
   logic [WORD_W-1:0]    time_ff, time_in;
   logic [1:0]           axis_ff, axis_in;
   logic signed [DH_W-1:0] dh_ff, dh_in;
   logic                 rd_vld_ff, rd_vld_in;
   logic [1:0]           rd_axis_ff, rd_axis_in;
   logic                 mul_vld_ff, mul_vld_in;
   logic [1:0]           mul_axis_ff, mul_axis_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_word_type         rsp_data_ff, rsp_data_in;

   logic [FRAME_W-1:0]   frame_rd_ff;
   val_entry_type        val_rd_ff;
   logic [SLOT_W-1:0]    frame_rd_addr;
   logic [VAL_AW-1:0]    val_rd_addr;
   logic [VAL_AW-1:0]    val_wr_addr;
   logic                 mem_we;

   logic                 accept;
   logic [COUNT_W-1:0]   n_new;
   logic [FRAME_W-1:0]   whole;
   logic                 probe_le;
   logic [COUNT_W-1:0]   lo_step, hi_step, span, mid_step, sel_step;
   logic                 search_go;

   logic signed [WORD_W-1:0] pos_res, ori_res;

   assign accept = start && (state_ff == ST_IDLE);
   assign busy   = (state_ff != ST_IDLE);
   assign n_new  = (count_ff > MAX_COUNT) ? MAX_COUNT : count_ff;
   assign whole  = time_ff[WORD_W-1:FRAC_BITS];

   assign probe_le  = (frame_rd_ff <= whole);
   assign lo_step   = probe_le ? (COUNT_W'(mid_ff) + COUNT_W'(1)) : lo_ff;
   assign hi_step   = probe_le ? hi_ff : COUNT_W'(mid_ff);
   assign span      = hi_step - lo_step;
   assign mid_step  = lo_step + (span >> 1);
   assign search_go = (lo_step < hi_step);
   assign sel_step  = (lo_step == '0) ? (n_ff - COUNT_W'(1)) : (lo_step - COUNT_W'(1));

   assign val_wr_addr = VAL_AW'({req_data.slot, 1'b0}) + VAL_AW'(req_data.slot)
                      + VAL_AW'(req_data.axis);
   assign val_rd_addr = VAL_AW'({sel_ff, 1'b0}) + VAL_AW'(sel_ff) + VAL_AW'(axis_ff);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         frame_mem[req_data.slot] <= req_data.key_frame;
         val_mem[val_wr_addr]     <= '{req_data.load_position,
                                       req_data.load_position_delta,
                                       req_data.load_orientation,
                                       req_data.load_orientation_delta};
      end
      frame_rd_ff <= frame_mem[frame_rd_addr];
      val_rd_ff   <= val_mem[val_rd_addr];
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && (req_data.opcode == OP_SAMPLE) && (n_new != '0)) begin
               state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            if (!search_go) begin
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            if (axis_ff == AXIS_Z) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (mul_vld_ff && (mul_axis_ff == AXIS_Z)) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      n_in          = n_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      mid_in        = mid_ff;
      sel_in        = sel_ff;
      time_in       = time_ff;
      axis_in       = axis_ff;
      dh_in         = dh_ff;
      rd_vld_in     = 1'b0;
      rd_axis_in    = axis_ff;
      mul_vld_in    = rd_vld_ff;
      mul_axis_in   = rd_axis_ff;
      rsp_valid_in  = 1'b0;
      rsp_data_in   = rsp_data_ff;
      frame_rd_addr = mid_ff;
      mem_we        = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_data.opcode == OP_LOAD) begin
                  mem_we       = (req_data.axis inside {AXIS_X, AXIS_Y, AXIS_Z});
                  rsp_data_in  = '0;
                  rsp_valid_in = 1'b1;
               end else begin
                  time_in = req_data.query_time;
                  n_in    = n_new;
                  if (n_new == '0) begin
                     rsp_data_in             = '0;
                     rsp_data_in.empty_track = 1'b1;
                     rsp_valid_in            = 1'b1;
                  end else begin
                     lo_in                   = '0;
                     hi_in                   = n_new;
                     mid_in                  = SLOT_W'(n_new >> 1);
                     frame_rd_addr           = SLOT_W'(n_new >> 1);
                     rsp_data_in.empty_track = 1'b0;
                  end
               end
            end
         end
         ST_SEARCH: begin
            lo_in = lo_step;
            hi_in = hi_step;
            if (search_go) begin
               mid_in        = SLOT_W'(mid_step);
               frame_rd_addr = SLOT_W'(mid_step);
            end else begin
               sel_in        = SLOT_W'(sel_step);
               frame_rd_addr = SLOT_W'(sel_step);
               axis_in       = AXIS_X;
            end
         end
         ST_FETCH: begin
            if (axis_ff == AXIS_X) begin
               dh_in = $signed({1'b0, whole}) - $signed({1'b0, frame_rd_ff});
            end
            rd_vld_in  = 1'b1;
            rd_axis_in = axis_ff;
            axis_in    = axis_ff + 2'd1;
         end
         ST_DRAIN: begin
            axis_in = axis_ff;
         end
         default: begin
            axis_in = axis_ff;
         end
      endcase

      if (mul_vld_ff) begin
         case (mul_axis_ff)
            AXIS_X: begin
               rsp_data_in.pos_x = pos_res;
               rsp_data_in.ori_x = ori_res;
            end
            AXIS_Y: begin
               rsp_data_in.pos_y = pos_res;
               rsp_data_in.ori_y = ori_res;
            end
            AXIS_Z: begin
               rsp_data_in.pos_z = pos_res;
               rsp_data_in.ori_z = ori_res;
               rsp_valid_in      = 1'b1;
            end
            default: begin
               rsp_valid_in = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rd_vld_ff    <= 1'b0;
         mul_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_vld_ff    <= rd_vld_in;
         mul_vld_ff   <= mul_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            count_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      n_ff        <= n_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      mid_ff      <= mid_in;
      sel_ff      <= sel_in;
      time_ff     <= time_in;
      axis_ff     <= axis_in;
      dh_ff       <= dh_in;
      rd_axis_ff  <= rd_axis_in;
      mul_axis_ff <= mul_axis_in;
      rsp_data_ff <= rsp_data_in;
   end

   kts_extrap u_pos_extrap (
      .clock  (clock),
      .value  (val_rd_ff.position),
      .delta  (val_rd_ff.position_delta),
      .dh     (dh_ff),
      .dl     (time_ff[FRAC_BITS-1:0]),
      .result (pos_res)
   );

   kts_extrap u_ori_extrap (
      .clock  (clock),
      .value  (val_rd_ff.orientation),
      .delta  (val_rd_ff.orientation_delta),
      .dh     (dh_ff),
      .dl     (time_ff[FRAC_BITS-1:0]),
      .result (ori_res)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `KTS_ASSERT_IMPL(a_rsp_when_idle, clock, reset, rsp_valid, !busy)
   `KTS_ASSERT_IMPL(a_search_bounds, clock, reset, state_ff == ST_SEARCH,
                    (lo_ff < hi_ff) && (hi_ff <= n_ff))
   `KTS_ASSERT_IMPL(a_mul_in_sample, clock, reset, mul_vld_ff,
                    (state_ff == ST_FETCH) || (state_ff == ST_DRAIN))
   `KTS_ASSERT_NEXT(a_load_answers, clock, reset, accept && (req_data.opcode == OP_LOAD),
                    rsp_valid)

endmodule

`default_nettype wire
